// ===== hw/rtl/point_in_polygon_test_assert.svh =====
// Assertion macros shared by the point-in-polygon RTL.
// Expects clk and rst_n in the including module's scope; no other dependencies.
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppt assertion failed (same cycle)");

// Next-cycle implication, disabled in reset.
`define PPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppt assertion failed (next cycle)");

`endif

// ===== hw/rtl/ppt_pkg.sv =====
// Package for the point-in-polygon block: request/result payloads, request codes,
// controller-datapath command and status bundles. No dependencies.
`default_nettype none

package ppt_pkg;

    localparam int COORD_BITS = 32;
    localparam int COUNT_BITS = 7;
    localparam int DIFF_BITS  = COORD_BITS + 1;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_code_t;

    typedef struct packed {
        logic [1:0]                   req_type;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
    } request_t;

    typedef struct packed {
        logic                  inside_res;
        logic [COUNT_BITS-1:0] vertex_count;
        logic                  status;
    } result_t;

    typedef struct packed {
        logic accept;
        logic walk_step;
        logic respond;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic walk_done;
        logic pipe_idle;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ppt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ppt_ctrl.sv =====
// Controller state machine: accepts requests, sequences the edge walk and the response.
// Depends on ppt_pkg.
`default_nettype none

module ppt_ctrl
    import ppt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] req_type,
    input  wire status_t    st,
    output cmd_t            cmd,
    output logic            busy
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = start;
                if (start && req_type == REQ_QUERY && !st.count_zero)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (st.walk_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (st.pipe_idle)
                begin
                    cmd.respond = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/ppt_datapath.sv =====
// Datapath: vertex stores, count, edge walk pipeline with exact cross-multiplied
// crossing test, and the result register. Depends on ppt_pkg, ppt_ram and the assert header.
`default_nettype none
`include "point_in_polygon_test_assert.svh"

module ppt_datapath
    import ppt_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire request_t request,
    input  wire cmd_t     cmd,
    output status_t       st,
    output result_t       result,
    output logic          done
);

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int OW  = (CW > COUNT_BITS) ? CW : COUNT_BITS;
    localparam int LOW = DIFF_BITS / 2;
    localparam int HIW = DIFF_BITS - LOW;
    localparam int PL  = DIFF_BITS + LOW + 1;
    localparam int PH  = DIFF_BITS + HIW;
    localparam int PF  = 2 * DIFF_BITS;

    // Count and walk control
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] step_reg, step_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic          rd_vld_reg, rd_first_reg;
    logic          inside_reg, inside_next;
    logic          done_reg, done_next;
    result_t       res_reg, res_next;

    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;

    logic [CW-1:0] count_m1;
    logic [OW-1:0] count_wide;
    logic          is_full;
    logic          is_append, is_query;
    logic          walk_start;
    logic          ram_we;

    logic [COORD_BITS-1:0]        rdata_x, rdata_y;
    logic signed [COORD_BITS-1:0] xi, yi;

    // Stage 2: differences
    logic                        v2_reg, span2_reg, dpos2_reg;
    logic signed [DIFF_BITS-1:0] dxp_reg, d_reg, dxe_reg, dyp_reg;
    logic                        span_c;

    // Stage 3: partial products
    logic                 v3_reg, span3_reg, dpos3_reg;
    logic signed [PL-1:0] pl1_reg, pl2_reg;
    logic signed [PH-1:0] ph1_reg, ph2_reg;

    // Stage 4: full products
    logic                 v4_reg, span4_reg, dpos4_reg;
    logic signed [PF-1:0] p1_reg, p2_reg;
    logic                 cross_c;

    assign is_append  = (request.req_type == REQ_APPEND);
    assign is_query   = (request.req_type == REQ_QUERY);
    assign is_full    = (count_reg == CW'(MAX_VERTICES));
    assign count_m1   = count_reg - CW'(1);
    assign walk_start = cmd.accept && is_query && (count_reg != '0);
    assign ram_we     = cmd.accept && is_append && !is_full;

    ppt_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_ram_x (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (request.coord_x),
        .re    (cmd.walk_step),
        .raddr (rd_addr_reg),
        .rdata (rdata_x)
    );

    ppt_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_ram_y (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (request.coord_y),
        .re    (cmd.walk_step),
        .raddr (rd_addr_reg),
        .rdata (rdata_y)
    );

    assign xi = $signed(rdata_x);
    assign yi = $signed(rdata_y);

    // Request handling and walk sequencing
    always_comb
    begin
        count_next   = count_reg;
        step_next    = step_reg;
        rd_addr_next = rd_addr_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        if (cmd.accept)
        begin
            case (request.req_type)
                REQ_APPEND:
                begin
                    if (!is_full)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                REQ_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
            count_wide          = OW'(count_next);
            res_next.inside_res = 1'b0;
            res_next.vertex_count = count_wide[COUNT_BITS-1:0];
            res_next.status     = is_append && is_full;
            done_next           = !walk_start;
            step_next           = '0;
            rd_addr_next        = count_m1[AW-1:0];
        end
        else
        begin
            count_wide = OW'(count_reg);
            if (cmd.walk_step)
            begin
                step_next    = step_reg + CW'(1);
                rd_addr_next = (step_reg == '0) ? '0 : rd_addr_reg + AW'(1);
            end
            if (cmd.respond)
            begin
                res_next.inside_res   = inside_reg;
                res_next.vertex_count = count_wide[COUNT_BITS-1:0];
                res_next.status       = 1'b0;
                done_next             = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            step_reg     <= '0;
            rd_addr_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            step_reg     <= step_next;
            rd_addr_reg  <= rd_addr_next;
            rd_vld_reg   <= cmd.walk_step;
            rd_first_reg <= cmd.walk_step && (step_reg == '0);
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (walk_start)
        begin
            px_reg <= request.coord_x;
            py_reg <= request.coord_y;
        end
        if (rd_vld_reg)
        begin
            prev_x_reg <= xi;
            prev_y_reg <= yi;
        end
    end

    // Edge pipeline: j is the previous read, i the current one
    assign span_c = ((yi <= py_reg) && (py_reg < prev_y_reg)) ||
                    ((prev_y_reg <= py_reg) && (py_reg < yi));

    always_ff @(posedge clk)
    begin
        span2_reg <= span_c;
        dpos2_reg <= (prev_y_reg > yi);
        dxp_reg   <= {px_reg[COORD_BITS-1], px_reg} - {xi[COORD_BITS-1], xi};
        d_reg     <= {prev_y_reg[COORD_BITS-1], prev_y_reg} - {yi[COORD_BITS-1], yi};
        dxe_reg   <= {prev_x_reg[COORD_BITS-1], prev_x_reg} - {xi[COORD_BITS-1], xi};
        dyp_reg   <= {py_reg[COORD_BITS-1], py_reg} - {yi[COORD_BITS-1], yi};

        span3_reg <= span2_reg;
        dpos3_reg <= dpos2_reg;
        pl1_reg   <= PL'(dxp_reg) * PL'($signed({1'b0, d_reg[LOW-1:0]}));
        ph1_reg   <= PH'(dxp_reg) * PH'($signed(d_reg[DIFF_BITS-1:LOW]));
        pl2_reg   <= PL'(dxe_reg) * PL'($signed({1'b0, dyp_reg[LOW-1:0]}));
        ph2_reg   <= PH'(dxe_reg) * PH'($signed(dyp_reg[DIFF_BITS-1:LOW]));

        span4_reg <= span3_reg;
        dpos4_reg <= dpos3_reg;
        p1_reg    <= (PF'(ph1_reg) <<< LOW) + PF'(pl1_reg);
        p2_reg    <= (PF'(ph2_reg) <<< LOW) + PF'(pl2_reg);
    end

    assign cross_c = dpos4_reg ? (p1_reg < p2_reg) : (p1_reg > p2_reg);

    always_comb
    begin
        inside_next = inside_reg;
        if (walk_start)
        begin
            inside_next = 1'b0;
        end
        else if (v4_reg && span4_reg && cross_c)
        begin
            inside_next = !inside_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            inside_reg <= 1'b0;
        end
        else
        begin
            v2_reg     <= rd_vld_reg && !rd_first_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
            inside_reg <= inside_next;
        end
    end

    assign st.count_zero = (count_reg == '0);
    assign st.walk_done  = (step_reg == count_reg);
    assign st.pipe_idle  = !rd_vld_reg && !v2_reg && !v3_reg && !v4_reg;

    assign result = res_reg;
    assign done   = done_reg;

    `PPT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_VERTICES))
    `PPT_ASSERT_NOW(a_drop_only_full, done_reg && res_reg.status, count_reg == CW'(MAX_VERTICES))
    `PPT_ASSERT_NOW(a_walk_in_range, cmd.walk_step, step_reg <= count_reg)

endmodule

`default_nettype wire

// ===== hw/rtl/point_in_polygon_test.sv =====
// Top level of the point-in-polygon block: controller plus datapath.
// Depends on ppt_pkg, ppt_ctrl, ppt_datapath and the assert header.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  request   | start / busy       | request (req_type, coord_x, coord_y)
//  result    | done (one cycle)   | result (inside_res, vertex_count, status)
//
// Append, clear, unused codes and a query on an empty polygon: result in the cycle
// after the request, busy never rises.
// Query on n vertices: busy rises, and the result appears in the cycle busy falls;
// the walk issues one vertex read per cycle from the coordinate RAMs (n + 1 reads),
// then a four-stage multiply and compare pipeline drains.
// Reset clears the vertex count; the coordinate stores need no clearing pass.
// The result cannot be stalled; it holds from done until the next accepted request.
`default_nettype none
`include "point_in_polygon_test_assert.svh"

module point_in_polygon_test
    import ppt_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire request_t request,
    output logic          busy,
    output logic          done,
    output result_t       result
);

    cmd_t    cmd;
    status_t st;

    ppt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .st       (st),
        .cmd      (cmd),
        .busy     (busy)
    );

    ppt_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .st      (st),
        .result  (result),
        .done    (done)
    );

    `PPT_ASSERT_NOW(a_no_result_while_busy, busy, !done)
    `PPT_ASSERT_NEXT(a_simple_req_one_cycle, start && !busy && request.req_type != REQ_QUERY, done && !busy)

endmodule

`default_nettype wire
